// ----- rtl/rsh_pkg.sv -----
// Shared types, constants and helpers for the region size histogram.
package rsh_pkg;

  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_MAX_BINS  = 64;

  localparam int NUM_W = 28;  // widest dividend: clamped area times bin count
  localparam int DEN_W = 22;  // widest divisor: width limit times height limit
  localparam int DIM_W = 12;  // grid dimension, up to 2047
  localparam int BITS_W = 5;

  localparam logic [BITS_W-1:0] SMALL_BITS = 5'd11;
  localparam logic [BITS_W-1:0] BIG_BITS   = 5'd28;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_READ_CELL = 2'd2;
  localparam logic [1:0] OP_READ_BIN = 2'd3;

  localparam logic [2:0] REG_CELL_SIZE    = 3'd0;
  localparam logic [2:0] REG_WIDTH_LIMIT  = 3'd1;
  localparam logic [2:0] REG_HEIGHT_LIMIT = 3'd2;
  localparam logic [2:0] REG_BIN_TOTAL    = 3'd3;
  localparam logic [2:0] REG_BIN_QUANTITY = 3'd4;

  localparam logic [1:0] QTY_HEIGHT = 2'd0;
  localparam logic [1:0] QTY_WIDTH  = 2'd1;
  localparam logic [1:0] QTY_AREA   = 2'd2;

  localparam logic [7:0]  RST_CELL_SIZE    = 8'd16;
  localparam logic [10:0] RST_WIDTH_LIMIT  = 11'd640;
  localparam logic [10:0] RST_HEIGHT_LIMIT = 11'd480;
  localparam logic [6:0]  RST_BIN_TOTAL    = 7'd0;
  localparam logic [1:0]  RST_BIN_QUANTITY = 2'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] region_width;
    logic [10:0] region_height;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic [5:0]  bin_number;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] read_value;
    logic [31:0] region_total;
    logic [5:0]  chosen_bin;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  cell_size;
    logic [10:0] width_limit;
    logic [10:0] height_limit;
    logic [6:0]  bin_total;
    logic [1:0]  bin_quantity;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } ctl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/rsh_ram.sv -----
// Generic single write port RAM with registered read.
module rsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rsh_div.sv -----
// Restoring divider, one quotient bit per cycle over a chosen number of bits.
module rsh_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsh_pkg::BITS_W-1:0] bits,
  input  logic [rsh_pkg::NUM_W-1:0]  num,
  input  logic [rsh_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [rsh_pkg::NUM_W-1:0]  quo
);
  import rsh_pkg::*;

  logic              busy;
  logic [BITS_W-1:0] idx;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem, num_r[idx]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        idx  <= bits - BITS_W'(1);
      end else if (busy) begin
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
          idx  <= idx - BITS_W'(1);
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/rsh_front.sv -----
// Intake side: two-entry queue that takes items and hands them to the back end.
module rsh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rsh_pkg::in_item_t req_item,
  output rsh_pkg::queue_t   head,
  input  rsh_pkg::ctl_t     ctl
);
  import rsh_pkg::*;

  in_item_t   entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign req_stall  = (count == 2'd2) || ctl.busy;
  assign push       = req_valid && !req_stall;
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (ctl.pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, ctl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= req_item;
    end
  end

endmodule

// ----- rtl/rsh_back.sv -----
// Execution side: sequencer with shared divider, count stores and result register.
module rsh_back #(
  parameter int GRID_COLS = rsh_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = rsh_pkg::DEF_GRID_ROWS,
  parameter int MAX_BINS  = rsh_pkg::DEF_MAX_BINS
) (
  input  logic               clk,
  input  logic               rst,
  input  rsh_pkg::cfg_t      cfg,
  input  logic               cfg_clear,
  input  rsh_pkg::queue_t    head,
  output rsh_pkg::ctl_t      ctl,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsh_pkg::out_item_t rsp_item
);
  import rsh_pkg::*;

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int BIN_AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SWEEP_N = (CELLS > MAX_BINS) ? CELLS : MAX_BINS;
  localparam int SW_W    = $clog2(SWEEP_N + 1);
  localparam int FULL_W  = 24;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIM_C  = 4'd1;
  localparam logic [3:0] S_DIM_R  = 4'd2;
  localparam logic [3:0] S_SWEEP  = 4'd3;
  localparam logic [3:0] S_DIV_X  = 4'd4;
  localparam logic [3:0] S_DIV_Y  = 4'd5;
  localparam logic [3:0] S_MUL_A  = 4'd6;
  localparam logic [3:0] S_MUL_B  = 4'd7;
  localparam logic [3:0] S_DIV_B  = 4'd8;
  localparam logic [3:0] S_UPD_RD = 4'd9;
  localparam logic [3:0] S_UPD_WR = 4'd10;
  localparam logic [3:0] S_RD_W   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]        state;
  logic              pend;
  logic              clr_rsp;
  in_item_t          item;
  logic [10:0]       x;
  logic [10:0]       y;
  logic [DIM_W-1:0]  gcols;
  logic [DIM_W-1:0]  grows;
  logic [ADDR_W-1:0] idx;
  logic              in_grid;
  logic [DEN_W-1:0]  v_reg;
  logic [DEN_W-1:0]  range_reg;
  logic [5:0]        chosen;
  logic              res_status;
  logic              res_read_cell;
  logic              res_read_bin;
  logic [31:0]       res_read;
  logic [31:0]       total;
  logic [SW_W-1:0]   cnt;

  logic [7:0]        eff_cell;
  logic [10:0]       eff_w;
  logic [10:0]       eff_h;
  logic [6:0]        n_act;
  logic [DEN_W-1:0]  v_cl;
  logic [NUM_W-1:0]  prod_b;
  logic              rd_cell_ok;
  logic              rd_bin_ok;
  logic [FULL_W-1:0] rd_full;
  logic [FULL_W-1:0] add_full;
  logic [DIM_W-1:0]  q_dim;
  logic              out_load;

  logic                  div_start;
  logic [BITS_W-1:0]     div_bits;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;

  logic                  cell_we;
  logic [ADDR_W-1:0]     cell_waddr;
  logic [31:0]           cell_wdata;
  logic [ADDR_W-1:0]     cell_raddr;
  logic [31:0]           cell_rdata;
  logic                  bin_we;
  logic [BIN_AW-1:0]     bin_waddr;
  logic [31:0]           bin_wdata;
  logic [BIN_AW-1:0]     bin_raddr;
  logic [31:0]           bin_rdata;

  assign eff_cell = (cfg.cell_size == '0) ? 8'd1 : cfg.cell_size;
  assign eff_w    = (cfg.width_limit == '0) ? 11'd1 : cfg.width_limit;
  assign eff_h    = (cfg.height_limit == '0) ? 11'd1 : cfg.height_limit;
  assign n_act    = (cfg.bin_quantity > QTY_AREA) ? 7'd0 :
                    (cfg.bin_total > 7'(MAX_BINS)) ? 7'(MAX_BINS) : cfg.bin_total;

  assign v_cl   = (v_reg > range_reg - DEN_W'(1)) ? range_reg - DEN_W'(1) : v_reg;
  assign prod_b = NUM_W'(v_cl) * NUM_W'(n_act);

  assign rd_cell_ok = (DIM_W'(head.item.cell_column) < gcols) &&
                      (DIM_W'(head.item.cell_row) < grows);
  assign rd_bin_ok  = 7'(head.item.bin_number) < n_act;
  assign rd_full    = FULL_W'(head.item.cell_row) * FULL_W'(GRID_COLS) +
                      FULL_W'(head.item.cell_column);
  assign add_full   = FULL_W'(y) * FULL_W'(GRID_COLS) + FULL_W'(x);
  assign q_dim      = DIM_W'(div_quo[10:0]);

  assign ctl.pop  = (state == S_IDLE) && !pend && head.valid;
  assign ctl.busy = pend || (state == S_DIM_C) || (state == S_DIM_R) || (state == S_SWEEP);

  assign out_load = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  // Divider operands, issued on the cycle the sequencer moves into a divide state
  always_comb begin
    div_start = 1'b0;
    div_bits  = SMALL_BITS;
    div_num   = '0;
    div_den   = DEN_W'(eff_cell);
    case (state)
      S_IDLE: begin
        if (pend || (head.valid && head.item.op == OP_CLEAR)) begin
          div_start = 1'b1;
          div_num   = NUM_W'(eff_w);
        end else if (head.valid && head.item.op == OP_ADD) begin
          div_start = 1'b1;
          div_num   = NUM_W'(head.item.region_width);
        end
      end
      S_DIM_C: begin
        div_start = div_done;
        div_num   = NUM_W'(eff_h);
      end
      S_DIV_X: begin
        div_start = div_done;
        div_num   = NUM_W'(item.region_height);
      end
      S_MUL_B: begin
        div_start = (n_act != 7'd0);
        div_bits  = BIG_BITS;
        div_num   = prod_b;
        div_den   = range_reg;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = idx;
    cell_wdata = sat_inc(cell_rdata);
    bin_we     = 1'b0;
    bin_waddr  = chosen[BIN_AW-1:0];
    bin_wdata  = sat_inc(bin_rdata);
    cell_raddr = idx;
    bin_raddr  = chosen[BIN_AW-1:0];
    case (state)
      S_IDLE: begin
        cell_raddr = rd_full[ADDR_W-1:0];
        bin_raddr  = head.item.bin_number[BIN_AW-1:0];
      end
      S_SWEEP: begin
        cell_we    = cnt < SW_W'(CELLS);
        cell_waddr = cnt[ADDR_W-1:0];
        cell_wdata = '0;
        bin_we     = cnt < SW_W'(MAX_BINS);
        bin_waddr  = cnt[BIN_AW-1:0];
        bin_wdata  = '0;
      end
      S_UPD_WR: begin
        cell_we = in_grid;
        bin_we  = (n_act != 7'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b1;
      rsp_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (cfg_clear) begin
        pend <= 1'b1;
      end else if (state == S_IDLE) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pend) begin
            total <= '0;
            state <= S_DIM_C;
          end else if (head.valid) begin
            case (head.item.op)
              OP_ADD:       state <= S_DIV_X;
              OP_CLEAR: begin
                total <= '0;
                state <= S_DIM_C;
              end
              OP_READ_CELL: state <= rd_cell_ok ? S_RD_W : S_OUT;
              default:      state <= rd_bin_ok ? S_RD_W : S_OUT;
            endcase
          end
        end
        S_DIM_C: if (div_done) state <= S_DIM_R;
        S_DIM_R: if (div_done) state <= S_SWEEP;
        S_SWEEP: begin
          if (cnt == SW_W'(SWEEP_N - 1)) begin
            state <= clr_rsp ? S_OUT : S_IDLE;
          end
        end
        S_DIV_X: if (div_done) state <= S_DIV_Y;
        S_DIV_Y: if (div_done) state <= S_MUL_A;
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= (n_act != 7'd0) ? S_DIV_B : S_UPD_RD;
        S_DIV_B: if (div_done) state <= S_UPD_RD;
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: begin
          total <= sat_inc(total);
          state <= S_OUT;
        end
        S_RD_W: state <= S_OUT;
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        item          <= head.item;
        clr_rsp       <= !pend;
        chosen        <= '0;
        res_read      <= '0;
        res_read_cell <= head.item.op == OP_READ_CELL;
        res_read_bin  <= head.item.op == OP_READ_BIN;
        res_status    <= ((head.item.op == OP_READ_CELL) && !rd_cell_ok) ||
                         ((head.item.op == OP_READ_BIN) && !rd_bin_ok);
        cnt           <= '0;
      end
      S_DIM_C: if (div_done) gcols <= (q_dim > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : q_dim;
      S_DIM_R: if (div_done) grows <= (q_dim > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : q_dim;
      S_SWEEP: cnt <= cnt + SW_W'(1);
      S_DIV_X: if (div_done) x <= div_quo[10:0];
      S_DIV_Y: if (div_done) y <= div_quo[10:0];
      S_MUL_A: begin
        idx     <= add_full[ADDR_W-1:0];
        in_grid <= (DIM_W'(x) < gcols) && (DIM_W'(y) < grows);
        case (cfg.bin_quantity)
          QTY_HEIGHT: begin
            v_reg     <= DEN_W'(item.region_height);
            range_reg <= DEN_W'(eff_h);
          end
          QTY_WIDTH: begin
            v_reg     <= DEN_W'(item.region_width);
            range_reg <= DEN_W'(eff_w);
          end
          default: begin
            v_reg     <= DEN_W'(item.region_width) * DEN_W'(item.region_height);
            range_reg <= DEN_W'(eff_w) * DEN_W'(eff_h);
          end
        endcase
      end
      S_DIV_B: begin
        if (div_done) begin
          chosen <= (div_quo >= NUM_W'(n_act)) ? 6'(n_act - 7'd1) : div_quo[5:0];
        end
      end
      S_UPD_WR: res_status <= !in_grid;
      S_RD_W: begin
        if (res_read_cell) begin
          res_read <= cell_rdata;
        end else if (res_read_bin) begin
          res_read <= bin_rdata;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      rsp_item.status       <= res_status;
      rsp_item.read_value   <= res_read;
      rsp_item.region_total <= total;
      rsp_item.chosen_bin   <= chosen;
    end
  end

  rsh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .bits  (div_bits),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rsh_ram #(.WIDTH(32), .DEPTH(CELLS), .AW(ADDR_W)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  rsh_ram #(.WIDTH(32), .DEPTH(MAX_BINS), .AW(BIN_AW)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

endmodule

// ----- rtl/roi_size_histogram_top.sv -----
// Region size histogram: 2D cell histogram, 1D bins and region total.
// Add region: two 11-bit divisions on the shared one-bit-per-cycle divider, and with binning
//   a 28-bit division. Read cell or bin: a RAM read, skipped when the index is out of range.
// Clear: two 11-bit divisions for the grid size, then a sweep over max(cells, bins) entries.
//   One item at a time; a two-entry queue takes transfers meanwhile, but not during a clear.
// Synchronous reset and known-register writes start a clearing pass; no item is taken then.
module roi_size_histogram_top #(
  parameter int GRID_COLS = rsh_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = rsh_pkg::DEF_GRID_ROWS,
  parameter int MAX_BINS  = rsh_pkg::DEF_MAX_BINS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  rsh_pkg::in_item_t  req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsh_pkg::out_item_t rsp_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rsh_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic       cfg_clear;
  logic [2:0] reg_idx;
  queue_t     head;
  ctl_t       ctl;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register file; a write to a known register also requests a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size    <= RST_CELL_SIZE;
      cfg.width_limit  <= RST_WIDTH_LIMIT;
      cfg.height_limit <= RST_HEIGHT_LIMIT;
      cfg.bin_total    <= RST_BIN_TOTAL;
      cfg.bin_quantity <= RST_BIN_QUANTITY;
      cfg_clear        <= 1'b0;
    end else begin
      cfg_clear <= cfg_wr && (reg_idx <= REG_BIN_QUANTITY);
      if (cfg_wr) begin
        case (reg_idx)
          REG_CELL_SIZE:    cfg.cell_size    <= pwdata[7:0];
          REG_WIDTH_LIMIT:  cfg.width_limit  <= pwdata[10:0];
          REG_HEIGHT_LIMIT: cfg.height_limit <= pwdata[10:0];
          REG_BIN_TOTAL:    cfg.bin_total    <= pwdata[6:0];
          REG_BIN_QUANTITY: cfg.bin_quantity <= pwdata[1:0];
          default: begin
            // drop writes beyond the map
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CELL_SIZE:    prdata = 32'(cfg.cell_size);
      REG_WIDTH_LIMIT:  prdata = 32'(cfg.width_limit);
      REG_HEIGHT_LIMIT: prdata = 32'(cfg.height_limit);
      REG_BIN_TOTAL:    prdata = 32'(cfg.bin_total);
      REG_BIN_QUANTITY: prdata = 32'(cfg.bin_quantity);
      default:          prdata = '0;
    endcase
  end

  // Front end: hold incoming transfers in the queue
  rsh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .head      (head),
    .ctl       (ctl)
  );

  // Back end: divide, bin, update the stores and register the result
  rsh_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .MAX_BINS  (MAX_BINS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .head      (head),
    .ctl       (ctl),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule

// ----- rtl/rsh_checker.sv -----
// Port-level checks for the region size histogram, bound to the top level.
module rsh_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input rsh_pkg::out_item_t rsp_item
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result shown straight after reset");

  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status |-> rsp_item.read_value == 32'd0)
    else $error("failed item carries a read value");

  a_bin_only_add: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_item.chosen_bin != 6'd0) |->
      rsp_item.read_value == 32'd0 && rsp_item.region_total != 32'd0)
    else $error("bin reported for an item that added nothing");

endmodule

bind roi_size_histogram_top rsh_checker u_rsh_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for the region size histogram: driver, monitor, predictor and stimulus.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsh_pkg::*;

  localparam int COLS      = 64;
  localparam int ROWS      = 64;
  localparam int BINS      = 64;
  localparam int IN_W      = $bits(in_item_t);
  // A clear walks 4096 cells; leave plenty of room for that plus stalls.
  localparam int IDLE_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  in_item_t    req_item = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b1;
  out_item_t   rsp_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  roi_size_histogram_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's configuration and count stores.
  logic [31:0] cell_shadow [COLS*ROWS];
  logic [31:0] bin_shadow [BINS];
  logic [31:0] total_shadow;
  cfg_t        cfg;

  in_item_t    pending_items [$];
  out_item_t   expected_results [$];

  int send_idle = 0;   // percent of cycles the sender holds off
  int recv_idle = 0;   // percent of cycles the receiver stalls
  bit hold_send = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int adds_sent = 0;
  int configs_used = 1;
  int quiet_cycles = 0;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void wipe_counts();
    foreach (cell_shadow[i]) cell_shadow[i] = '0;
    foreach (bin_shadow[i]) bin_shadow[i] = '0;
    total_shadow = '0;
  endfunction

  function automatic int unsigned cell_px();
    return (cfg.cell_size == 0) ? 1 : cfg.cell_size;
  endfunction

  function automatic int unsigned wlim();
    return (cfg.width_limit == 0) ? 1 : cfg.width_limit;
  endfunction

  function automatic int unsigned hlim();
    return (cfg.height_limit == 0) ? 1 : cfg.height_limit;
  endfunction

  function automatic int unsigned grid_w();
    int unsigned c;
    c = wlim() / cell_px();
    return (c > COLS) ? COLS : c;
  endfunction

  function automatic int unsigned grid_h();
    int unsigned r;
    r = hlim() / cell_px();
    return (r > ROWS) ? ROWS : r;
  endfunction

  function automatic int unsigned live_bins();
    if (cfg.bin_quantity > QTY_AREA) return 0;
    return (cfg.bin_total > BINS) ? BINS : cfg.bin_total;
  endfunction

  // Work out the result of one item and advance the shadow state.
  function automatic out_item_t histogram_outcome(in_item_t it);
    out_item_t        r;
    int unsigned      x, y, n;
    longint unsigned  v, span, b;
    r = '0;
    case (it.op)
      OP_ADD: begin
        x = it.region_width / cell_px();
        y = it.region_height / cell_px();
        n = live_bins();
        total_shadow = bump(total_shadow);
        if (x < grid_w() && y < grid_h())
          cell_shadow[y*COLS + x] = bump(cell_shadow[y*COLS + x]);
        else
          r.status = 1'b1;
        if (n != 0) begin
          if (cfg.bin_quantity == QTY_HEIGHT) begin
            v = it.region_height;
            span = hlim();
          end else if (cfg.bin_quantity == QTY_WIDTH) begin
            v = it.region_width;
            span = wlim();
          end else begin
            v = longint'(it.region_width) * it.region_height;
            span = longint'(wlim()) * hlim();
          end
          if (v > span - 1) v = span - 1;
          b = (v * n) / span;
          if (b >= n) b = n - 1;
          bin_shadow[b] = bump(bin_shadow[b]);
          r.chosen_bin = b[5:0];
        end
      end
      OP_CLEAR: wipe_counts();
      OP_READ_CELL: begin
        if (it.cell_column < grid_w() && it.cell_row < grid_h())
          r.read_value = cell_shadow[it.cell_row*COLS + it.cell_column];
        else
          r.status = 1'b1;
      end
      default: begin
        if (it.bin_number < live_bins())
          r.read_value = bin_shadow[it.bin_number];
        else
          r.status = 1'b1;
      end
    endcase
    r.region_total = total_shadow;
    return r;
  endfunction

  // Driver: predict on every accepted transfer, then offer the next item or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_results.push_back(histogram_outcome(req_item));
        items_sent++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_items.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          req_item  <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, rsp_item);
        end else begin
          want = expected_results.pop_front();
          if (rsp_item.status !== want.status ||
              rsp_item.read_value !== want.read_value ||
              rsp_item.region_total !== want.region_total ||
              rsp_item.chosen_bin !== want.chosen_bin) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_item);
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic in_item_t add_item(int w, int h);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom}));
    it.op = OP_ADD;
    it.region_width = 11'(w);
    it.region_height = 11'(h);
    return it;
  endfunction

  function automatic in_item_t cell_item(int c, int r);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom}));
    it.op = OP_READ_CELL;
    it.cell_column = 6'(c);
    it.cell_row = 6'(r);
    return it;
  endfunction

  function automatic in_item_t bin_item(int b);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom}));
    it.op = OP_READ_BIN;
    it.bin_number = 6'(b);
    return it;
  endfunction

  function automatic in_item_t clear_item();
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom}));
    it.op = OP_CLEAR;
    return it;
  endfunction

  // Wait until the block has nothing left in flight.
  task automatic drain();
    while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CELL_SIZE:    cfg.cell_size = val[7:0];
      REG_WIDTH_LIMIT:  cfg.width_limit = val[10:0];
      REG_HEIGHT_LIMIT: cfg.height_limit = val[10:0];
      REG_BIN_TOTAL:    cfg.bin_total = val[6:0];
      default:          cfg.bin_quantity = val[1:0];
    endcase
    wipe_counts();
  endtask

  task automatic apply_setup(int cs, int wl, int hl, int bt, int q);
    drain();
    reg_write(REG_CELL_SIZE, cs);
    reg_write(REG_WIDTH_LIMIT, wl);
    reg_write(REG_HEIGHT_LIMIT, hl);
    reg_write(REG_BIN_TOTAL, bt);
    reg_write(REG_BIN_QUANTITY, q);
    configs_used++;
  endtask

  // Queue a random mix, mostly adds inside the configured limits with reads back.
  task automatic queue_random(int count);
    int k, w, h;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(99)) inside
        [0:57]: begin
          if ($urandom_range(9) == 0) begin
            w = $urandom_range(2047);
            h = $urandom_range(2047);
          end else begin
            w = $urandom_range(wlim() + wlim() / 8);
            h = $urandom_range(hlim() + hlim() / 8);
          end
          pending_items.push_back(add_item(w, h));
          adds_sent++;
        end
        [58:78]: begin
          if ($urandom_range(4) == 0)
            pending_items.push_back(cell_item($urandom_range(63), $urandom_range(63)));
          else
            pending_items.push_back(cell_item($urandom_range(grid_w()),
                                              $urandom_range(grid_h())));
        end
        [79:98]: pending_items.push_back(bin_item($urandom_range(live_bins())
                                                  + $urandom_range(1) * $urandom_range(63)));
        default: pending_items.push_back(clear_item());
      endcase
    end
  endtask

  initial begin
    cfg = '{cell_size: RST_CELL_SIZE, width_limit: RST_WIDTH_LIMIT,
            height_limit: RST_HEIGHT_LIMIT, bin_total: RST_BIN_TOTAL,
            bin_quantity: RST_BIN_QUANTITY};
    wipe_counts();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, edges of the grid, every operation.
    send_idle = 15;
    recv_idle = 51;
    pending_items.push_back(add_item(0, 0));
    pending_items.push_back(add_item(2047, 2047));
    pending_items.push_back(add_item(639, 479));
    pending_items.push_back(add_item(640, 0));
    pending_items.push_back(add_item(0, 480));
    pending_items.push_back(cell_item(0, 0));
    pending_items.push_back(cell_item(39, 29));
    pending_items.push_back(cell_item(40, 0));
    pending_items.push_back(cell_item(63, 63));
    pending_items.push_back(bin_item(0));
    pending_items.push_back(clear_item());
    pending_items.push_back(cell_item(0, 0));
    adds_sent += 5;

    // Binning on, extremes of the grid and bin count.
    apply_setup(1, 64, 64, 64, QTY_AREA);
    pending_items.push_back(add_item(63, 63));
    pending_items.push_back(add_item(2047, 0));
    pending_items.push_back(add_item(0, 2047));
    pending_items.push_back(bin_item(63));
    pending_items.push_back(bin_item(0));
    pending_items.push_back(cell_item(63, 63));
    adds_sent += 3;
    queue_random(300);

    // Hold the sender with items still waiting until every result is back, then carry on.
    queue_random(40);
    repeat (60) @(posedge clk);
    hold_send = 1'b1;
    while (req_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    hold_send = 1'b0;

    send_idle = 51;
    recv_idle = 15;
    apply_setup(128, 1920, 1080, 64, QTY_WIDTH);
    queue_random(300);
    apply_setup(3, 1920, 1080, 7, QTY_HEIGHT);
    queue_random(300);
    // Zero cell size and limits, oversized bin count, then an unknown quantity.
    apply_setup(0, 0, 0, 100, QTY_AREA);
    pending_items.push_back(add_item(0, 0));
    pending_items.push_back(add_item(1, 1));
    adds_sent += 2;
    queue_random(150);
    apply_setup(255, 2047, 2047, 127, 3);
    queue_random(150);

    send_idle = 0;
    recv_idle = 0;
    apply_setup(16, 640, 480, 16, QTY_WIDTH);
    queue_random(300);
    apply_setup(5, 100, 37, 33, QTY_AREA);
    queue_random(300);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d items (%0d region adds) over %0d register settings, %0d results.",
             items_sent, adds_sent, configs_used, results_seen);
    $display("Sender and receiver stalls were swept through three idle patterns.");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/rsh_pkg.sv
rtl/rsh_ram.sv
rtl/rsh_div.sv
rtl/rsh_front.sv
rtl/rsh_back.sv
rtl/roi_size_histogram_top.sv
rtl/rsh_checker.sv
bench/tb.sv
